### hw/rtl/mphd_pkg.sv
// ----------------------------------------------------------------------------
// mphd_pkg
// Shared types, constants and helpers for the meter peak hold / decay core.
// ----------------------------------------------------------------------------
package mphd_pkg;

    // Default build values
    localparam int DEF_HOLD_UPDATES = 5;
    localparam int DEF_LEVEL_BITS   = 24;

    // Peak floors in Q15.8, before clamping to the level range
    localparam longint FLOOR_RX  = -51200;
    localparam longint FLOOR_PWR = 0;
    localparam longint FLOOR_ALC = -25600;

    // Watts to milliwatts
    localparam int MW_SCALE      = 1000;
    localparam int MW_SCALE_BITS = 11;

    localparam int STEP_BITS  = 7;
    localparam int RANGE_BITS = 3;

    // Configuration register index
    typedef enum logic [0:0] {
        REG_AMP_BYPASSED = 1'b0,
        REG_AMP_RANGE    = 1'b1
    } cfg_index_t;

    // Amplifier rating codes
    typedef enum logic [RANGE_BITS-1:0] {
        RANGE_1W   = 3'd0,
        RANGE_10W  = 3'd1,
        RANGE_30W  = 3'd2,
        RANGE_50W  = 3'd3,
        RANGE_100W = 3'd4,
        RANGE_200W = 3'd5,
        RANGE_500W = 3'd6
    } amp_range_t;

    localparam logic [STEP_BITS-1:0] STEP_MW      = 7'd100;
    localparam logic [STEP_BITS-1:0] STEP_DEFAULT = 7'd10;

    // Scale interval per division for a given amplifier rating
    function automatic logic [STEP_BITS-1:0] scale_step_of(input logic [RANGE_BITS-1:0] rng);
        logic [STEP_BITS-1:0] s;
        case (rng)
            RANGE_1W:   s = STEP_MW;
            RANGE_10W:  s = 7'd1;
            RANGE_30W:  s = 7'd3;
            RANGE_50W:  s = 7'd5;
            RANGE_100W: s = 7'd10;
            RANGE_200W: s = 7'd20;
            RANGE_500W: s = 7'd50;
            default:    s = STEP_DEFAULT;
        endcase
        return s;
    endfunction

endpackage

### hw/rtl/mphd_ifs.sv
// ----------------------------------------------------------------------------
// mphd_ifs
// Valid/ready channels of the meter core: readings in, results out, config.
// ----------------------------------------------------------------------------

// Meter reading channel
interface mphd_in_if
    import mphd_pkg::*;
#(
    parameter int LEVEL_BITS = DEF_LEVEL_BITS
)
();
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [LEVEL_BITS-1:0] reading;
    logic signed [LEVEL_BITS-1:0] exciter_power;
    logic signed [LEVEL_BITS-1:0] alc_level;

    modport source (output valid, kind, reading, exciter_power, alc_level, input ready);
    modport sink   (input valid, kind, reading, exciter_power, alc_level, output ready);
endinterface

// Displayed meter result channel
interface mphd_out_if
    import mphd_pkg::*;
#(
    parameter int LEVEL_BITS = DEF_LEVEL_BITS
)
();
    logic                         valid;
    logic                         ready;
    logic signed [LEVEL_BITS-1:0] shown_level;
    logic signed [LEVEL_BITS-1:0] shown_alc;
    logic                         milliwatt_units;
    logic [STEP_BITS-1:0]         scale_step;

    modport source (output valid, shown_level, shown_alc, milliwatt_units, scale_step,
                    input ready);
    modport sink   (input valid, shown_level, shown_alc, milliwatt_units, scale_step,
                    output ready);
endinterface

// Configuration write channel
interface mphd_cfg_if
    import mphd_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [0:0]            index;
    logic [RANGE_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/meter_peak_hold_decay_core.sv
// ----------------------------------------------------------------------------
// meter_peak_hold_decay_core
// Peak hold with exponential decay for receive level, power and ALC meters.
// ----------------------------------------------------------------------------
// Every accepted reading yields exactly one result. The reading is held in the
// input register, and from there the decay, compare and scaling logic loads
// the peak and result registers, so the result shows on the output once the
// result ahead of it, if any, leaves. A new item is taken every cycle while
// the output is not stalled; throughput is one item per clock, set by the
// single-pass path from the input register into the peak registers, which
// also feeds the next item. The output register decouples the sides, so a
// reading is taken while a result still waits. Config writes are always
// ready and take effect on the next computed item; write them only while
// the core is idle.
// ----------------------------------------------------------------------------
module meter_peak_hold_decay_core
    import mphd_pkg::*;
#(
    parameter int HOLD_UPDATES = DEF_HOLD_UPDATES,
    parameter int LEVEL_BITS   = DEF_LEVEL_BITS
)
(
    input logic          clk,
    input logic          rst_n,
    mphd_in_if.sink      meter_in,
    mphd_out_if.source   meter_out,
    mphd_cfg_if.sink     cfg
);

    localparam int W      = LEVEL_BITS;
    localparam int HOLD_W = $clog2(HOLD_UPDATES + 2);
    localparam int MW_W   = W + MW_SCALE_BITS;

    // Floors clamped to the representable range
    localparam longint LVL_MIN_L = -(64'sd1 <<< (W - 1));
    localparam longint FLR_RX_L  = (FLOOR_RX  < LVL_MIN_L) ? LVL_MIN_L : FLOOR_RX;
    localparam longint FLR_PWR_L = (FLOOR_PWR < LVL_MIN_L) ? LVL_MIN_L : FLOOR_PWR;
    localparam longint FLR_ALC_L = (FLOOR_ALC < LVL_MIN_L) ? LVL_MIN_L : FLOOR_ALC;
    localparam logic signed [W-1:0] FLR_RX  = W'(FLR_RX_L);
    localparam logic signed [W-1:0] FLR_PWR = W'(FLR_PWR_L);
    localparam logic signed [W-1:0] FLR_ALC = W'(FLR_ALC_L);

    localparam logic [HOLD_W-1:0] HOLD_LIMIT = HOLD_W'(HOLD_UPDATES);

    typedef struct packed {
        logic signed [W-1:0] level;
        logic                fresh;
    } track_t;

    // Saturate a two-bit-wider sum to the level range
    function automatic logic signed [W-1:0] sat_decay(input logic signed [W+1:0] v);
        logic signed [W-1:0] r;
        if (v[W+1:W-1] == 3'b000 || v[W+1:W-1] == 3'b111)
            r = v[W-1:0];
        else
            r = v[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        return r;
    endfunction

    // Saturate the milliwatt product to the level range
    function automatic logic signed [W-1:0] sat_mw(input logic signed [MW_W-1:0] v);
        logic signed [W-1:0] r;
        if (v[MW_W-1:W-1] == '0 || v[MW_W-1:W-1] == '1)
            r = v[W-1:0];
        else
            r = v[MW_W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        return r;
    endfunction

    // Optional decay toward the new value, floor, then jump up on a new peak
    function automatic track_t track(
        input logic signed [W-1:0] peak,
        input logic signed [W-1:0] val,
        input logic signed [W-1:0] flo,
        input logic                dec
    );
        track_t              t;
        logic signed [W+1:0] sum;
        logic signed [W-1:0] p;
        sum = {{2{peak[W-1]}}, peak} - (W+2)'(peak >>> 2) + (W+2)'(val >>> 2);
        p   = peak;
        if (dec)
        begin
            p = sat_decay(sum);
            if (p < flo)
                p = flo;
        end
        t.fresh = (val > p);
        t.level = t.fresh ? val : p;
        return t;
    endfunction

    // Configuration registers
    logic                  amp_bypassed_reg;
    logic [RANGE_BITS-1:0] amp_range_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_bypassed_reg <= 1'b0;
            amp_range_reg    <= RANGE_100W;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_AMP_BYPASSED: amp_bypassed_reg <= cfg.data[0];
                REG_AMP_RANGE:    amp_range_reg    <= cfg.data;
                default:          ;
            endcase
        end
    end

    // Input register
    logic                s_valid_reg;
    logic                s_kind_reg;
    logic signed [W-1:0] s_reading_reg;
    logic signed [W-1:0] s_exciter_reg;
    logic signed [W-1:0] s_alc_reg;
    logic                out_valid_reg;
    logic                advance;
    logic                take;

    assign advance        = s_valid_reg && (!out_valid_reg || meter_out.ready);
    assign meter_in.ready = !s_valid_reg || advance;
    assign take           = meter_in.valid && meter_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_valid_reg <= 1'b0;
        else if (meter_in.ready)
            s_valid_reg <= meter_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s_kind_reg    <= meter_in.kind;
            s_reading_reg <= meter_in.reading;
            s_exciter_reg <= meter_in.exciter_power;
            s_alc_reg     <= meter_in.alc_level;
        end
    end

    // Peak state
    logic                last_mode_reg, last_mode_next;
    logic signed [W-1:0] peak_rx_reg, peak_rx_next;
    logic signed [W-1:0] peak_pwr_reg, peak_pwr_next;
    logic signed [W-1:0] peak_alc_reg, peak_alc_next;
    logic [HOLD_W-1:0]   hold_reg, hold_next;

    // Result values
    logic signed [W-1:0]  level_next;
    logic                 mw_next;
    logic [STEP_BITS-1:0] step_next;

    // Single-pass update
    logic                  mode_change;
    logic signed [W-1:0]   cur_rx, cur_pwr, cur_alc;
    logic [HOLD_W-1:0]     cur_hold;
    logic                  decay;
    logic                  mw_mode;
    logic signed [W-1:0]   pwr_sel, pwr_val;
    logic signed [MW_W-1:0] pwr_prod;
    track_t                t_rx, t_pwr, t_alc;
    logic                  fresh;

    always_comb
    begin
        mode_change = (s_kind_reg != last_mode_reg);
        cur_rx   = mode_change ? FLR_RX  : peak_rx_reg;
        cur_pwr  = mode_change ? FLR_PWR : peak_pwr_reg;
        cur_alc  = mode_change ? FLR_ALC : peak_alc_reg;
        cur_hold = mode_change ? '0 : hold_reg;
        decay    = (cur_hold > HOLD_LIMIT);

        // Exciter power stands in for zero reading or bypassed amplifier
        pwr_sel  = (s_reading_reg == '0 || amp_bypassed_reg) ? s_exciter_reg : s_reading_reg;
        mw_mode  = amp_bypassed_reg || (amp_range_reg == RANGE_1W);
        pwr_prod = MW_W'(pwr_sel) * MW_W'(MW_SCALE);
        pwr_val  = mw_mode ? sat_mw(pwr_prod) : pwr_sel;

        t_rx  = track(cur_rx, s_reading_reg, FLR_RX, decay);
        t_pwr = track(cur_pwr, pwr_val, FLR_PWR, decay);
        t_alc = track(cur_alc, s_alc_reg, FLR_ALC, decay);

        last_mode_next = s_kind_reg;
        if (s_kind_reg)
        begin
            peak_rx_next  = cur_rx;
            peak_pwr_next = t_pwr.level;
            peak_alc_next = t_alc.level;
            fresh         = t_pwr.fresh || t_alc.fresh;
            level_next    = t_pwr.level;
            mw_next       = mw_mode;
            step_next     = mw_mode ? STEP_MW : scale_step_of(amp_range_reg);
        end
        else
        begin
            peak_rx_next  = t_rx.level;
            peak_pwr_next = cur_pwr;
            peak_alc_next = cur_alc;
            fresh         = t_rx.fresh;
            level_next    = t_rx.level;
            mw_next       = 1'b0;
            step_next     = STEP_DEFAULT;
        end

        // Hold counter restarts on a new peak, saturates one past the limit
        if (fresh)
            hold_next = HOLD_W'(1);
        else if (cur_hold <= HOLD_LIMIT)
            hold_next = cur_hold + HOLD_W'(1);
        else
            hold_next = cur_hold;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_mode_reg <= 1'b0;
            peak_rx_reg   <= FLR_RX;
            peak_pwr_reg  <= FLR_PWR;
            peak_alc_reg  <= FLR_ALC;
            hold_reg      <= '0;
        end
        else if (advance)
        begin
            last_mode_reg <= last_mode_next;
            peak_rx_reg   <= peak_rx_next;
            peak_pwr_reg  <= peak_pwr_next;
            peak_alc_reg  <= peak_alc_next;
            hold_reg      <= hold_next;
        end
    end

    // Result register
    logic signed [W-1:0]  level_reg;
    logic signed [W-1:0]  alc_out_reg;
    logic                 mw_reg;
    logic [STEP_BITS-1:0] step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (meter_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            level_reg   <= level_next;
            alc_out_reg <= peak_alc_next;
            mw_reg      <= mw_next;
            step_reg    <= step_next;
        end
    end

    assign meter_out.valid           = out_valid_reg;
    assign meter_out.shown_level     = level_reg;
    assign meter_out.shown_alc       = alc_out_reg;
    assign meter_out.milliwatt_units = mw_reg;
    assign meter_out.scale_step      = step_reg;

endmodule

### hw/rtl/mphd_checker.sv
// ----------------------------------------------------------------------------
// mphd_checker
// Port-level checks on the result channel of the meter core.
// ----------------------------------------------------------------------------
module mphd_checker
    import mphd_pkg::*;
#(
    parameter int LEVEL_BITS = DEF_LEVEL_BITS
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [LEVEL_BITS-1:0] shown_level,
    input logic signed [LEVEL_BITS-1:0] shown_alc,
    input logic                         milliwatt_units,
    input logic [STEP_BITS-1:0]         scale_step
);

    localparam longint LVL_MIN_L = -(64'sd1 <<< (LEVEL_BITS - 1));
    localparam longint FLR_RX_L  = (FLOOR_RX  < LVL_MIN_L) ? LVL_MIN_L : FLOOR_RX;
    localparam longint FLR_ALC_L = (FLOOR_ALC < LVL_MIN_L) ? LVL_MIN_L : FLOOR_ALC;
    localparam logic signed [LEVEL_BITS-1:0] FLR_RX  = LEVEL_BITS'(FLR_RX_L);
    localparam logic signed [LEVEL_BITS-1:0] FLR_ALC = LEVEL_BITS'(FLR_ALC_L);

    // A stalled result keeps its values
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(shown_level)
            && $stable(shown_alc) && $stable(milliwatt_units) && $stable(scale_step))
        else $error("result changed while stalled");

    // Held ALC never sinks below its floor
    a_alc_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> shown_alc >= FLR_ALC)
        else $error("ALC peak below floor");

    // Shown level never sinks below the lowest floor
    a_level_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> shown_level >= FLR_RX)
        else $error("shown level below floor");

    // Milliwatt display always uses the coarsest scale
    a_mw_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && milliwatt_units |-> scale_step == STEP_MW)
        else $error("milliwatt result with wrong scale step");

endmodule

bind meter_peak_hold_decay_core mphd_checker #(
    .LEVEL_BITS (LEVEL_BITS)
) u_mphd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (meter_out.valid),
    .out_ready       (meter_out.ready),
    .shown_level     (meter_out.shown_level),
    .shown_alc       (meter_out.shown_alc),
    .milliwatt_units (meter_out.milliwatt_units),
    .scale_step      (meter_out.scale_step)
);
